// ===== design/bitplane_text_extractor_defines.svh =====
// Assertion macros used by the checker file bte_checker.sv.
`ifndef BITPLANE_TEXT_EXTRACTOR_DEFINES_SVH
`define BITPLANE_TEXT_EXTRACTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitplane_text_extractor: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitplane_text_extractor: assertion failed");

`endif

// ===== design/bte_pkg.sv =====
package bte_pkg;

    localparam logic [7:0] CHAR_T      = 8'h54;
    localparam logic [7:0] CHAR_X      = 8'h58;
    localparam int         BYTE_BITS   = 8;
    localparam logic [4:0] HEADER_BITS = 5'(3 * BYTE_BITS);
    localparam logic [4:0] X_DONE_BITS = 5'(2 * BYTE_BITS);

    localparam logic [2:0]  BIT_PLANE_RESET = 3'd0;
    localparam logic [15:0] MAX_CHARS_RESET = 16'd1024;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_HEADER   = 2'd1,
        STAT_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_BIT_PLANE = 2'd0,
        CFG_MAX_CHARS = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]  bit_plane;
        logic [15:0] max_chars;
    } t_cfg;

    typedef struct packed {
        logic        char_valid;
        logic [7:0]  char_value;
        logic [15:0] char_index;
        logic        final_res;
        t_status     status;
    } t_result;

endpackage

// ===== design/bte_cfg.sv =====
module bte_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    output bte_pkg::t_cfg o_cfg
);

    logic [2:0]  r_bit_plane;
    logic [15:0] r_max_chars;
    logic [2:0]  n_bit_plane;
    logic [15:0] n_max_chars;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_bit_plane = r_bit_plane;
        n_max_chars = r_max_chars;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                bte_pkg::CFG_BIT_PLANE: n_bit_plane = i_cfg_data[2:0];
                bte_pkg::CFG_MAX_CHARS: n_max_chars = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_plane <= bte_pkg::BIT_PLANE_RESET;
            r_max_chars <= bte_pkg::MAX_CHARS_RESET;
        end else begin
            r_bit_plane <= n_bit_plane;
            r_max_chars <= n_max_chars;
        end
    end

    assign o_cfg.bit_plane = r_bit_plane;
    assign o_cfg.max_chars = r_max_chars;

endmodule

// ===== design/bte_core.sv =====
module bte_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bte_pkg::t_cfg    i_cfg,
    input  logic             i_step,
    input  logic [7:0]       i_pixel,
    input  logic             i_last_pixel,
    output logic             o_has_res,
    output bte_pkg::t_result o_res
);

    logic [7:0]       r_bit_shift;
    logic [2:0]       r_bit_count;
    logic [4:0]       r_header_pixels;
    logic [15:0]      r_char_count;
    bte_pkg::t_status r_fail_code;

    logic [7:0]       n_bit_shift;
    logic [2:0]       n_bit_count;
    logic [4:0]       n_header_pixels;
    logic [15:0]      n_char_count;
    bte_pkg::t_status n_fail_code;

    logic       byte_done;
    logic       emit;
    logic [7:0] want;

    always_comb begin
        n_bit_shift     = {r_bit_shift[6:0], i_pixel[i_cfg.bit_plane]};
        n_bit_count     = r_bit_count + 3'd1;
        n_header_pixels = r_header_pixels;
        n_char_count    = r_char_count;
        n_fail_code     = r_fail_code;
        byte_done       = (n_bit_count == 3'd0);
        emit            = 1'b0;
        want            = bte_pkg::CHAR_T;

        if (r_header_pixels < bte_pkg::HEADER_BITS) begin
            n_header_pixels = r_header_pixels + 5'd1;
            if (n_header_pixels == bte_pkg::X_DONE_BITS) begin
                want = bte_pkg::CHAR_X;
            end
            if (byte_done && n_bit_shift != want && r_fail_code == bte_pkg::STAT_OK) begin
                n_fail_code = bte_pkg::STAT_HEADER;
            end
        end else if (r_fail_code == bte_pkg::STAT_OK && byte_done) begin
            if (r_char_count >= i_cfg.max_chars) begin
                n_fail_code = bte_pkg::STAT_OVERFLOW;
            end else begin
                emit         = 1'b1;
                n_char_count = r_char_count + 16'd1;
            end
        end

        if (i_last_pixel && n_header_pixels < bte_pkg::HEADER_BITS
                && n_fail_code == bte_pkg::STAT_OK) begin
            n_fail_code = bte_pkg::STAT_HEADER;
        end

        o_has_res        = emit || i_last_pixel;
        o_res.char_valid = emit;
        o_res.char_value = emit ? n_bit_shift : 8'd0;
        o_res.char_index = emit ? r_char_count : 16'd0;
        o_res.final_res  = i_last_pixel;
        o_res.status     = n_fail_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_shift     <= 8'd0;
            r_bit_count     <= 3'd0;
            r_header_pixels <= 5'd0;
            r_char_count    <= 16'd0;
            r_fail_code     <= bte_pkg::STAT_OK;
        end else if (i_step) begin
            if (i_last_pixel) begin
                r_bit_shift     <= 8'd0;
                r_bit_count     <= 3'd0;
                r_header_pixels <= 5'd0;
                r_char_count    <= 16'd0;
                r_fail_code     <= bte_pkg::STAT_OK;
            end else begin
                r_bit_shift     <= n_bit_shift;
                r_bit_count     <= n_bit_count;
                r_header_pixels <= n_header_pixels;
                r_char_count    <= n_char_count;
                r_fail_code     <= n_fail_code;
            end
        end
    end

endmodule

// ===== design/bitplane_text_extractor.sv =====
// A pixel accepted into the input register is stepped through the extraction logic, and any
// result word it yields is registered in the output register. Throughput: one pixel per
// cycle unless the output stalls, set by the input register feeding the extraction logic.
// A stalled result word holds the input register, and the input stalls once both are full.
// Reset (synchronous, active low) clears the valid flags of both pipeline registers and the
// extraction state and sets bit_plane to 0 and max_chars to 1024.
module bitplane_text_extractor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_pixel,
    input  logic        i_last_pixel,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_char_valid,
    output logic [7:0]  o_char_value,
    output logic [15:0] o_char_index,
    output logic        o_final_res,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    bte_pkg::t_cfg    cfg;
    bte_pkg::t_result core_res;
    logic             core_has_res;

    logic             r_in_valid;
    logic [7:0]       r_pixel;
    logic             r_last_pixel;
    logic             r_out_valid;
    bte_pkg::t_result r_res;

    logic             out_free;
    logic             step;
    logic             in_accept;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    bte_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bte_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_step       (step),
        .i_pixel      (r_pixel),
        .i_last_pixel (r_last_pixel),
        .o_has_res    (core_has_res),
        .o_res        (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pixel      <= i_pixel;
            r_last_pixel <= i_last_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && core_has_res) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && core_has_res) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_char_valid = r_res.char_valid;
    assign o_char_value = r_res.char_value;
    assign o_char_index = r_res.char_index;
    assign o_final_res  = r_res.final_res;
    assign o_status     = r_res.status;

endmodule

// ===== design/bte_checker.sv =====
`include "bitplane_text_extractor_defines.svh"

module bte_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_char_valid,
    input logic [7:0]  o_char_value,
    input logic [15:0] o_char_index,
    input logic        o_final_res,
    input logic [1:0]  o_status
);

    logic        mid_word;
    logic        empty_char;
    logic        out_held;
    logic [27:0] res_word;

    assign mid_word   = o_out_valid && !o_final_res;
    assign empty_char = (o_char_value == 8'd0) && (o_char_index == 16'd0);
    assign out_held   = o_out_valid && i_out_stall;
    assign res_word   = {o_char_valid, o_char_value, o_char_index, o_final_res, o_status};

    // Every result word carries a character, a final status, or both.
    `BTE_ASSERT_SAME(a_word_has_content, i_clk, i_rst_n, o_out_valid, o_char_valid || o_final_res)

    // Characters are only given while the run is good, so status is ok on them.
    `BTE_ASSERT_SAME(a_status_ok_midrun, i_clk, i_rst_n, mid_word, o_status == bte_pkg::STAT_OK)

    // A word without a character shows zero value and index.
    `BTE_ASSERT_SAME(a_empty_char_zero, i_clk, i_rst_n, o_out_valid && !o_char_valid, empty_char)

    // A stalled result word holds.
    `BTE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(res_word))

endmodule

bind bitplane_text_extractor bte_checker u_bte_checker (.*);
